// ===== rtl/fpn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpn_pkg: shared types and constants of the fullwidth punctuation normalizer
// Word formats of both channels, the translation result bundle and the
// fullwidth-to-ASCII mapping.
// ----------------------------------------------------------------------------
package fpn_pkg;

	// Input word: one source byte and the final-byte mark.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_word_t;

	// Output word: one text byte, or the terminator with out_last set.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_word_t;

	// Everything one input byte produces: up to four output words and the
	// next window and count state.
	typedef struct packed {
		logic [3:0][7:0] text;
		logic [2:0]      cnt;
		logic            last;
		logic [1:0][7:0] win;
		logic [1:0]      win_cnt;
		logic [7:0]      out_count;
	} xlate_t;

	localparam logic [7:0] MAX_OUT_RST = 8'd255;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] LEAD3_MIN  = 8'hE0;
	localparam logic [7:0] LEAD_CJK   = 8'hE3;
	localparam logic [7:0] LEAD_FW    = 8'hEF;
	localparam logic [7:0] MID_FW     = 8'hBC;
	localparam logic [7:0] MID_CJK    = 8'h80;
	localparam logic [7:0] CJK_SPACE  = 8'h80;
	localparam logic [7:0] CJK_STOP   = 8'h82;
	localparam logic [7:0] CJK_LBRK   = 8'h90;
	localparam logic [7:0] CJK_RBRK   = 8'h91;

	localparam int unsigned FW_N = 7;
	localparam logic [FW_N-1:0][7:0] FW_CODES = {
		8'h89, 8'h88, 8'h9B, 8'h9A, 8'h9F, 8'h81, 8'h8C
	};
	localparam logic [FW_N-1:0][7:0] FW_ASCII = {
		8'h29, 8'h28, 8'h3B, 8'h3A, 8'h3F, 8'h21, 8'h2C
	};

	// Map a three-byte fullwidth punctuation group to ASCII; zero if none.
	function automatic logic [7:0] map_punct(input logic [7:0] b0,
		input logic [7:0] b1, input logic [7:0] b2);
		logic [7:0] r;
		r = CH_NUL;
		if (b0 == LEAD_FW && b1 == MID_FW) begin
			for (int k = 0; k < FW_N; k++) begin
				if (b2 == FW_CODES[k]) begin
					r = FW_ASCII[k];
				end
			end
		end else if (b0 == LEAD_CJK && b1 == MID_CJK) begin
			if (b2 == CJK_STOP) begin
				r = 8'h2E;
			end else if (b2 == CJK_LBRK) begin
				r = 8'h5B;
			end else if (b2 == CJK_RBRK) begin
				r = 8'h5D;
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/fpn_xlate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpn_xlate: translation of one input byte
// Combines the held window with the new byte, walks up to three positions
// and returns the output words and the next window and budget state.
// ----------------------------------------------------------------------------
module fpn_xlate (
	input  fpn_pkg::in_word_t        word,
	input  logic [1:0][7:0]          win,
	input  logic [1:0]               win_cnt,
	input  logic [7:0]               out_count,
	input  logic [7:0]               max_out,
	output fpn_pkg::xlate_t          res
);
	import fpn_pkg::*;

	logic [3:0][7:0] bytes;
	logic [1:0]      n;
	logic [1:0]      pos;
	logic [1:0]      avail;
	logic [7:0]      oc;
	logic [2:0]      cnt;
	logic [3:0][7:0] text;
	logic            stop;
	logic [7:0]      c;
	logic [7:0]      t;

	// Build the working buffer: held bytes first, the new byte after them.
	always_comb begin
		bytes = '0;
		case (win_cnt)
			2'd0: begin
				bytes[0] = word.in_byte;
				n = 2'd1;
			end
			2'd1: begin
				bytes[0] = win[0];
				bytes[1] = word.in_byte;
				n = 2'd2;
			end
			default: begin
				bytes[0] = win[0];
				bytes[1] = win[1];
				bytes[2] = word.in_byte;
				n = 2'd3;
			end
		endcase
	end

	// Walk the buffer; at most three positions, each a short decision.
	always_comb begin
		pos   = 2'd0;
		avail = 2'd0;
		oc    = out_count;
		cnt   = 3'd0;
		text  = '0;
		stop  = 1'b0;
		c     = CH_NUL;
		t     = map_punct(bytes[0], bytes[1], bytes[2]);
		for (int it = 0; it < 3; it++) begin
			if (!stop && pos < n && oc < max_out) begin
				c     = bytes[pos];
				avail = n - pos;
				if (c == CH_SPACE) begin
					pos = pos + 2'd1;
				end else if (c >= LEAD3_MIN) begin
					if (avail != 2'd3) begin
						// A lead byte short of its two followers waits unless the
						// string ends here.
						if (!word.in_last) begin
							stop = 1'b1;
						end else begin
							text[cnt[1:0]] = c;
							cnt = cnt + 3'd1;
							oc  = oc + 8'd1;
							pos = pos + 2'd1;
						end
					end else if (bytes[1] == MID_CJK && bytes[2] == CJK_SPACE
						&& c == LEAD_CJK) begin
						pos = 2'd3;
					end else if (t != CH_NUL) begin
						text[cnt[1:0]] = t;
						cnt = cnt + 3'd1;
						oc  = oc + 8'd1;
						pos = 2'd3;
					end else if ({1'b0, oc} + 9'd3 <= {1'b0, max_out}) begin
						// The whole group fits in the budget.
						text[0] = bytes[0];
						text[1] = bytes[1];
						text[2] = bytes[2];
						cnt = 3'd3;
						oc  = oc + 8'd3;
						pos = 2'd3;
					end else begin
						text[cnt[1:0]] = c;
						cnt = cnt + 3'd1;
						oc  = oc + 8'd1;
						pos = pos + 2'd1;
					end
				end else begin
					text[cnt[1:0]] = c;
					cnt = cnt + 3'd1;
					oc  = oc + 8'd1;
					pos = pos + 2'd1;
				end
			end
		end
		// Once the budget is spent, whatever is left is dropped.
		if (oc >= max_out) begin
			pos = n;
		end
	end

	// Close the string or keep the unconsumed bytes for the next word.
	always_comb begin
		res.text      = text;
		res.cnt       = cnt;
		res.last      = word.in_last;
		res.win[0]    = bytes[pos];
		res.win[1]    = bytes[pos + 2'd1];
		res.win_cnt   = n - pos;
		res.out_count = oc;
		if (word.in_last) begin
			res.text[cnt[1:0]] = CH_NUL;
			res.cnt       = cnt + 3'd1;
			res.win_cnt   = 2'd0;
			res.out_count = 8'd0;
		end
	end

endmodule

// ===== rtl/fullwidth_punct_normalizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fullwidth_punct_normalizer: UTF-8 fullwidth punctuation normalizer
// Drops spaces, maps fullwidth punctuation to ASCII, copies other bytes
// within the output budget and closes each string with a NUL word.
// ----------------------------------------------------------------------------
// Path: an accepted input word passes the input register, then the result register, before its first output word.
// Throughput: one input word per cycle while each word yields at most one
// output word and out_stall is low; a word yielding more words holds the input
// until the single-word output port has drained the four-entry result register.
// Reset: arst_n clears the window, budget count and pipeline; max_out is 255.
module fullwidth_punct_normalizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  fpn_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output fpn_pkg::out_word_t out_word,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data
);
	import fpn_pkg::*;

	in_word_t        in_word_s1;
	logic            in_valid_s1;
	logic [7:0]      max_out_q;
	logic [1:0][7:0] win_q;
	logic [1:0]      win_cnt_q;
	logic [7:0]      out_count_q;
	logic [3:0][7:0] res_text_q;
	logic [2:0]      res_left_q;
	logic [1:0]      res_rd_q;
	logic            res_last_q;
	xlate_t          xl;
	logic            adv;
	logic            out_take;

	fpn_xlate u_xlate (
		.word      (in_word_s1),
		.win       (win_q),
		.win_cnt   (win_cnt_q),
		.out_count (out_count_q),
		.max_out   (max_out_q),
		.res       (xl)
	);

	// Handshake control: the input register moves on once the result
	// register is empty or hands out its final word this cycle.
	assign out_valid = (res_left_q != 3'd0);
	assign out_take  = out_valid && !out_stall;
	assign adv       = in_valid_s1 && ((res_left_q == 3'd0)
		|| (res_left_q == 3'd1 && !out_stall));
	assign in_stall  = in_valid_s1 && !adv;
	assign cfg_ready = 1'b1;

	// Output word from the result register.
	assign out_word.out_byte = res_text_q[res_rd_q];
	assign out_word.out_last = res_last_q && (res_left_q == 3'd1);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_word_s1 <= in_word;
		end
	end

	// Budget register, window and string state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_out_q   <= MAX_OUT_RST;
			win_q       <= '0;
			win_cnt_q   <= 2'd0;
			out_count_q <= 8'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_out_q <= cfg_data;
			end
			if (adv) begin
				win_q       <= xl.win;
				win_cnt_q   <= xl.win_cnt;
				out_count_q <= xl.out_count;
			end
		end
	end

	// Result register: loaded with all words of one input, drained one a cycle while out_stall is low.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_left_q <= 3'd0;
			res_rd_q   <= 2'd0;
			res_last_q <= 1'b0;
		end else if (adv) begin
			res_left_q <= xl.cnt;
			res_rd_q   <= 2'd0;
			res_last_q <= xl.last;
		end else if (out_take) begin
			res_left_q <= res_left_q - 3'd1;
			res_rd_q   <= res_rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_text_q <= xl.text;
		end
	end

endmodule

// ===== rtl/fpn_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpn_chk: port-level checks of the fullwidth punctuation normalizer
// Watches the channel ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module fpn_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input fpn_pkg::in_word_t  in_word,
	input logic               out_valid,
	input logic               out_stall,
	input fpn_pkg::out_word_t out_word
);
	import fpn_pkg::*;

	// The input is only held back while results are waiting.
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no output pending");

	// A fresh burst of output comes from an accepted input word that has passed the input and result registers.
	a_output_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("output appeared without a matching input word");

	// A stalled input word stays in place.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_word))
		else $error("stalled input word changed");

	// A stalled output word stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled output word changed");

	// The terminator word carries a zero byte.
	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.out_last |-> out_word.out_byte == CH_NUL)
		else $error("terminator word with nonzero byte");

endmodule

bind fullwidth_punct_normalizer fpn_chk u_fpn_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_word   (in_word),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);
